/* rtl/core/hsv2rgb_pkg.sv */
// Shared types and constants for the HSV to RGB converter.
// No dependencies; used by hsv_to_rgb_converter_core.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int DEG_PER_SECTOR = 60;
    localparam int SECTORS        = 6;
    localparam int HUE_BITS       = 9;
    localparam int R_BITS         = 6;   // remainder within a sector, 0..59

    localparam logic [HUE_BITS-1:0] HUE_RANGE = HUE_BITS'(DEG_PER_SECTOR * SECTORS);

    typedef logic [2:0] sector_t;

    // Hue sectors, named by the colors at their ends
    localparam sector_t SEC_RY = 3'd0;
    localparam sector_t SEC_YG = 3'd1;
    localparam sector_t SEC_GC = 3'd2;
    localparam sector_t SEC_CB = 3'd3;
    localparam sector_t SEC_BM = 3'd4;
    localparam sector_t SEC_MR = 3'd5;

endpackage

/* rtl/core/hsv_to_rgb_converter_core.sv */
// HSV to RGB converter: nine-stage pipeline with a valid/ready stall chain.
// Depends on hsv2rgb_pkg for sector codes and hue constants.
`timescale 1ns / 1ps

// Converts one pixel per clock while the output side keeps up, from hue
// (whole degrees), saturation and value to red, green and blue, all channels
// being CHANNEL_BITS-bit fractions where the all-ones code means one. Every
// item passes nine register stages. Each stage holds its item only while
// the stage after it is full and stalled, so bubbles are squeezed out and
// in_ready drops only when all nine stages are full and out_ready is low.
// Hues of 360 and above wrap modulo 360. The terms p, q and t are exact
// truncated products; divisions by 60 and by the channel maximum use
// reciprocal multiplies and end-around-carry folding, with no divider.
module hsv_to_rgb_converter_core #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [hsv2rgb_pkg::HUE_BITS-1:0]      hue_deg,
    input  logic [CHANNEL_BITS-1:0]               sat,
    input  logic [CHANNEL_BITS-1:0]               val,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [CHANNEL_BITS-1:0]               red,
    output logic [CHANNEL_BITS-1:0]               green,
    output logic [CHANNEL_BITS-1:0]               blue
);

    localparam int N          = CHANNEL_BITS;
    localparam int R_BITS     = hsv2rgb_pkg::R_BITS;
    localparam int HB         = hsv2rgb_pkg::HUE_BITS;
    localparam int DEG        = hsv2rgb_pkg::DEG_PER_SECTOR;
    localparam int STAGES     = 9;
    localparam int U_BITS     = N + 6;            // holds up to 60 * max channel
    localparam int X_BITS     = 2 * N;            // holds up to max channel squared
    localparam int SH         = U_BITS + 6;       // exact floor(x/60) for x < 2^U_BITS
    localparam int RECIP_BITS = N + 7;
    localparam int PROD_BITS  = U_BITS + RECIP_BITS;
    localparam longint unsigned RECIP_FULL = ((64'd1 << SH) + DEG - 1) / DEG;
    localparam logic [RECIP_BITS-1:0] RECIP_K  = RECIP_BITS'(RECIP_FULL);
    localparam logic [N-1:0]          CH_MAX   = {N{1'b1}};
    localparam logic [X_BITS-1:0]     MAX_M1_X = X_BITS'((64'd1 << N) - 2);
    localparam logic [U_BITS-1:0]     DEG_U    = U_BITS'(DEG);
    localparam logic [U_BITS-1:0]     DEG_M1_U = U_BITS'(DEG - 1);
    localparam logic [R_BITS-1:0]     DEG_R    = R_BITS'(DEG);

    // ---------------------------------------------------------------
    // Stall chain: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------
    logic [STAGES:1] valid_reg;
    logic [STAGES:1] stage_en;

    always_comb
    begin
        stage_en[STAGES] = !valid_reg[STAGES] || out_ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    assign in_ready  = stage_en[1];
    assign out_valid = valid_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    // sector and value travel with the item
    hsv2rgb_pkg::sector_t sec_reg [1:8];
    logic [N-1:0]         v_reg   [1:8];

    // ---------------------------------------------------------------
    // Stage 1: wrap hue, split into sector and remainder
    // ---------------------------------------------------------------
    logic [HB-1:0]        h_mod;
    logic [HB-1:0]        h_base;
    hsv2rgb_pkg::sector_t sec1_next;
    logic [R_BITS-1:0]    r1_next;
    logic [R_BITS-1:0]    r1_reg;
    logic [N-1:0]         s1_reg;

    always_comb
    begin
        h_mod = (hue_deg >= hsv2rgb_pkg::HUE_RANGE) ? hue_deg - hsv2rgb_pkg::HUE_RANGE
                                                     : hue_deg;
        priority if (h_mod >= HB'(DEG * 5))
        begin
            sec1_next = hsv2rgb_pkg::SEC_MR;
            h_base    = HB'(DEG * 5);
        end
        else if (h_mod >= HB'(DEG * 4))
        begin
            sec1_next = hsv2rgb_pkg::SEC_BM;
            h_base    = HB'(DEG * 4);
        end
        else if (h_mod >= HB'(DEG * 3))
        begin
            sec1_next = hsv2rgb_pkg::SEC_CB;
            h_base    = HB'(DEG * 3);
        end
        else if (h_mod >= HB'(DEG * 2))
        begin
            sec1_next = hsv2rgb_pkg::SEC_GC;
            h_base    = HB'(DEG * 2);
        end
        else if (h_mod >= HB'(DEG))
        begin
            sec1_next = hsv2rgb_pkg::SEC_YG;
            h_base    = HB'(DEG);
        end
        else
        begin
            sec1_next = hsv2rgb_pkg::SEC_RY;
            h_base    = '0;
        end
        r1_next = R_BITS'(h_mod - h_base);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            sec_reg[1] <= sec1_next;
            r1_reg     <= r1_next;
            s1_reg     <= sat;
            v_reg[1]   <= val;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: u_q = r*s, u_t = (60-r)*s, w = v*s
    // ---------------------------------------------------------------
    logic [U_BITS-1:0] uq2_next, ut2_next, uq2_reg, ut2_reg;
    logic [X_BITS-1:0] w2_next, w_reg [2:6];

    always_comb
    begin
        uq2_next = U_BITS'(r1_reg) * U_BITS'(s1_reg);
        ut2_next = U_BITS'(DEG_R - r1_reg) * U_BITS'(s1_reg);
        w2_next  = X_BITS'(v_reg[1]) * X_BITS'(s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            uq2_reg    <= uq2_next;
            ut2_reg    <= ut2_next;
            w_reg[2]   <= w2_next;
            sec_reg[2] <= sec_reg[1];
            v_reg[2]   <= v_reg[1];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: a = floor(u/60) by reciprocal multiply
    // ---------------------------------------------------------------
    logic [PROD_BITS-1:0] pq3, pt3;
    logic [N-1:0]         aq3_reg, at3_reg;
    logic [U_BITS-1:0]    uq3_reg, ut3_reg;

    always_comb
    begin
        pq3 = PROD_BITS'(uq2_reg) * PROD_BITS'(RECIP_K);
        pt3 = PROD_BITS'(ut2_reg) * PROD_BITS'(RECIP_K);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            aq3_reg    <= pq3[SH +: N];
            at3_reg    <= pt3[SH +: N];
            uq3_reg    <= uq2_reg;
            ut3_reg    <= ut2_reg;
            w_reg[3]   <= w_reg[2];
            sec_reg[3] <= sec_reg[2];
            v_reg[3]   <= v_reg[2];
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: b = u - 60*a, the remainder below 60
    // ---------------------------------------------------------------
    logic [U_BITS-1:0] bq4_full, bt4_full;
    logic [R_BITS-1:0] bq4_reg, bt4_reg;
    logic [N-1:0]      aq4_reg, at4_reg;

    always_comb
    begin
        bq4_full = uq3_reg - U_BITS'(aq3_reg) * DEG_U;
        bt4_full = ut3_reg - U_BITS'(at3_reg) * DEG_U;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            bq4_reg    <= bq4_full[R_BITS-1:0];
            bt4_reg    <= bt4_full[R_BITS-1:0];
            aq4_reg    <= aq3_reg;
            at4_reg    <= at3_reg;
            w_reg[4]   <= w_reg[3];
            sec_reg[4] <= sec_reg[3];
            v_reg[4]   <= v_reg[3];
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: a*v and b*v + 59 (for the ceiling of b*v/60)
    // ---------------------------------------------------------------
    logic [X_BITS-1:0] avq5_next, avt5_next, avq5_reg, avt5_reg;
    logic [U_BITS-1:0] bvq5_next, bvt5_next, bvq5_reg, bvt5_reg;

    always_comb
    begin
        avq5_next = X_BITS'(aq4_reg) * X_BITS'(v_reg[4]);
        avt5_next = X_BITS'(at4_reg) * X_BITS'(v_reg[4]);
        bvq5_next = U_BITS'(bq4_reg) * U_BITS'(v_reg[4]) + DEG_M1_U;
        bvt5_next = U_BITS'(bt4_reg) * U_BITS'(v_reg[4]) + DEG_M1_U;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            avq5_reg   <= avq5_next;
            avt5_reg   <= avt5_next;
            bvq5_reg   <= bvq5_next;
            bvt5_reg   <= bvt5_next;
            w_reg[5]   <= w_reg[4];
            sec_reg[5] <= sec_reg[4];
            v_reg[5]   <= v_reg[4];
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: e = floor((b*v + 59)/60)
    // ---------------------------------------------------------------
    logic [PROD_BITS-1:0] pq6, pt6;
    logic [N-1:0]         eq6_reg, et6_reg;
    logic [X_BITS-1:0]    avq6_reg, avt6_reg;

    always_comb
    begin
        pq6 = PROD_BITS'(bvq5_reg) * PROD_BITS'(RECIP_K);
        pt6 = PROD_BITS'(bvt5_reg) * PROD_BITS'(RECIP_K);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            eq6_reg    <= pq6[SH +: N];
            et6_reg    <= pt6[SH +: N];
            avq6_reg   <= avq5_reg;
            avt6_reg   <= avt5_reg;
            w_reg[6]   <= w_reg[5];
            sec_reg[6] <= sec_reg[5];
            v_reg[6]   <= v_reg[5];
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: x = c + M - 1, so floor(x/M) is the ceiling of c/M
    // c = ceil(u*v/60) for q and t, c = v*s for p
    // ---------------------------------------------------------------
    logic [X_BITS-1:0] xq7_next, xt7_next, xp7_next;
    logic [X_BITS-1:0] xq7_reg, xt7_reg, xp7_reg;

    always_comb
    begin
        xq7_next = avq6_reg + X_BITS'(eq6_reg) + MAX_M1_X;
        xt7_next = avt6_reg + X_BITS'(et6_reg) + MAX_M1_X;
        xp7_next = w_reg[6] + MAX_M1_X;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            xq7_reg    <= xq7_next;
            xt7_reg    <= xt7_next;
            xp7_reg    <= xp7_next;
            sec_reg[7] <= sec_reg[6];
            v_reg[7]   <= v_reg[6];
        end
    end

    // ---------------------------------------------------------------
    // Stage 8: fold by M = 2^N - 1 and subtract from v
    // x < M*(2^N+1) keeps the folded remainder below 2M: one correction
    // ---------------------------------------------------------------
    function automatic logic [N-1:0] fold_sub(input logic [X_BITS-1:0] x,
                                              input logic [N-1:0]      v);
        logic [N:0]   rem;
        logic [N-1:0] quot;
        rem  = {1'b0, x[X_BITS-1:N]} + {1'b0, x[N-1:0]};
        quot = x[X_BITS-1:N] + N'(rem >= {1'b0, CH_MAX});
        return v - quot;
    endfunction

    logic [N-1:0] p8_reg, q8_reg, t8_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            p8_reg     <= fold_sub(xp7_reg, v_reg[7]);
            q8_reg     <= fold_sub(xq7_reg, v_reg[7]);
            t8_reg     <= fold_sub(xt7_reg, v_reg[7]);
            sec_reg[8] <= sec_reg[7];
            v_reg[8]   <= v_reg[7];
        end
    end

    // ---------------------------------------------------------------
    // Stage 9: sector mux into the output register
    // ---------------------------------------------------------------
    logic [N-1:0] red_next, green_next, blue_next;
    logic [N-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        unique case (sec_reg[8])
            hsv2rgb_pkg::SEC_RY:
            begin
                red_next = v_reg[8]; green_next = t8_reg;   blue_next = p8_reg;
            end
            hsv2rgb_pkg::SEC_YG:
            begin
                red_next = q8_reg;   green_next = v_reg[8]; blue_next = p8_reg;
            end
            hsv2rgb_pkg::SEC_GC:
            begin
                red_next = p8_reg;   green_next = v_reg[8]; blue_next = t8_reg;
            end
            hsv2rgb_pkg::SEC_CB:
            begin
                red_next = p8_reg;   green_next = q8_reg;   blue_next = v_reg[8];
            end
            hsv2rgb_pkg::SEC_BM:
            begin
                red_next = t8_reg;   green_next = p8_reg;   blue_next = v_reg[8];
            end
            default:
            begin
                red_next = v_reg[8]; green_next = p8_reg;   blue_next = q8_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[9])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[1])
        else $error("accepted item did not enter stage 1");

    a_stage1_split: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> (r1_reg < DEG_R) && (sec_reg[1] <= hsv2rgb_pkg::SEC_MR))
        else $error("hue split out of range");

    a_term_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[8] |-> (p8_reg <= q8_reg) && (p8_reg <= t8_reg)
                         && (q8_reg <= v_reg[8]) && (t8_reg <= v_reg[8]))
        else $error("p/q/t terms out of order");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!(&valid_reg) || out_ready))
        else $error("in_ready does not match pipeline occupancy");

endmodule

/* tb/tb.sv */
// Testbench for hsv_to_rgb_converter_core: directed and random pixels,
// checked against an in-bench HSV to RGB predictor under random stalls.
// Depends on hsv2rgb_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CB          = 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 24;
    localparam int NUM_RANDOM  = 700;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } rgb_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic [hsv2rgb_pkg::HUE_BITS-1:0] hue_deg   = '0;
    logic [CB-1:0]                    sat       = '0;
    logic [CB-1:0]                    val       = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [CB-1:0]                    red;
    logic [CB-1:0]                    green;
    logic [CB-1:0]                    blue;

    rgb_t expected_rgb[$];
    int   errors       = 0;
    int   idle_cycles  = 0;
    int   ready_hold   = 0;
    bit   free_run     = 1'b0;

    hsv_to_rgb_converter_core #(
        .CHANNEL_BITS(CB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .hue_deg   (hue_deg),
        .sat       (sat),
        .val       (val),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always #2 clk = ~clk;

    // Exact truncated p, q, t terms and the six-way sector mux
    function automatic rgb_t hsv_to_rgb(input logic [hsv2rgb_pkg::HUE_BITS-1:0] h,
                                        input logic [CB-1:0] s_in,
                                        input logic [CB-1:0] v_in);
        longint unsigned      hue;
        longint unsigned      rem;
        longint unsigned      s;
        longint unsigned      v;
        longint unsigned      m;
        longint unsigned      full;
        longint unsigned      p;
        longint unsigned      q;
        longint unsigned      t;
        hsv2rgb_pkg::sector_t sec;
        rgb_t                 c;
        hue  = h;
        s    = s_in;
        v    = v_in;
        m    = (64'd1 << CB) - 1;
        hue  = hue % (hsv2rgb_pkg::DEG_PER_SECTOR * hsv2rgb_pkg::SECTORS);
        sec  = hsv2rgb_pkg::sector_t'(hue / hsv2rgb_pkg::DEG_PER_SECTOR);
        rem  = hue % hsv2rgb_pkg::DEG_PER_SECTOR;
        full = hsv2rgb_pkg::DEG_PER_SECTOR * m;
        p    = (v * (m - s)) / m;
        q    = (v * (full - rem * s)) / full;
        t    = (v * (full - (hsv2rgb_pkg::DEG_PER_SECTOR - rem) * s)) / full;
        case (sec)
            hsv2rgb_pkg::SEC_RY: c = '{red: CB'(v), green: CB'(t), blue: CB'(p)};
            hsv2rgb_pkg::SEC_YG: c = '{red: CB'(q), green: CB'(v), blue: CB'(p)};
            hsv2rgb_pkg::SEC_GC: c = '{red: CB'(p), green: CB'(v), blue: CB'(t)};
            hsv2rgb_pkg::SEC_CB: c = '{red: CB'(p), green: CB'(q), blue: CB'(v)};
            hsv2rgb_pkg::SEC_BM: c = '{red: CB'(t), green: CB'(p), blue: CB'(v)};
            default:             c = '{red: CB'(v), green: CB'(p), blue: CB'(q)};
        endcase
        return c;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [CB-1:0] pick_chan();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return CB'($urandom);
    endfunction

    function automatic logic [hsv2rgb_pkg::HUE_BITS-1:0] pick_hue();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return hsv2rgb_pkg::HUE_BITS'($urandom_range(0, 359));
        else if (r < 95)
            return hsv2rgb_pkg::HUE_BITS'($urandom_range(360, 511));
        else
            return hsv2rgb_pkg::HUE_BITS'($urandom_range(0, 6) * hsv2rgb_pkg::DEG_PER_SECTOR
                                          - $urandom_range(0, 1) + 1);
    endfunction

    // Valid stays high across back-to-back items; it drops only for a gap
    task automatic send_pixel(input logic [hsv2rgb_pkg::HUE_BITS-1:0] h,
                              input logic [CB-1:0] s,
                              input logic [CB-1:0] v);
        int gap;
        gap = free_run ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        hue_deg  <= h;
        sat      <= s;
        val      <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_rgb.push_back(hsv_to_rgb(h, s, v));
    endtask

    task automatic test_extremes();
        send_pixel(9'd0,   8'd0,   8'd0);
        send_pixel(9'd0,   8'd255, 8'd255);
        send_pixel(9'd359, 8'd255, 8'd255);
        send_pixel(9'd0,   8'd255, 8'd0);
        send_pixel(9'd359, 8'd0,   8'd255);
        send_pixel(9'd180, 8'd128, 8'd255);
        send_pixel(9'd90,  8'd255, 8'd1);
    endtask

    // Both sides of each inner sector edge (60 to 300), all six sectors included
    task automatic test_sector_edges();
        for (int k = 1; k < hsv2rgb_pkg::SECTORS; k++)
        begin
            send_pixel(hsv2rgb_pkg::HUE_BITS'(k * hsv2rgb_pkg::DEG_PER_SECTOR - 1),
                       8'd200, 8'd250);
            send_pixel(hsv2rgb_pkg::HUE_BITS'(k * hsv2rgb_pkg::DEG_PER_SECTOR),
                       8'd200, 8'd250);
        end
    endtask

    // Hues of 360 and above wrap; 256 is a high hue that does not
    task automatic test_hue_wrap();
        send_pixel(9'd360, 8'd255, 8'd255);
        send_pixel(9'd400, 8'd170, 8'd210);
        send_pixel(9'd511, 8'd255, 8'd255);
        send_pixel(9'd256, 8'd85,  8'd255);
    endtask

    task automatic test_random();
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 100 == 0)
                free_run = ($urandom_range(0, 3) == 0);
            send_pixel(pick_hue(), pick_chan(), pick_chan());
        end
        free_run = 1'b0;
    endtask

    // Output side: ready held at a random level for random stretches, or high throughout a free run
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            out_ready  <= free_run || ($urandom_range(0, 3) != 0);
            ready_hold <= free_run ? 0 : idle_len();
        end
    end

    always @(posedge clk)
    begin
        rgb_t exp_c;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rgb.size() == 0)
            begin
                $error("result with no pending item: red %0d green %0d blue %0d",
                       red, green, blue);
                errors++;
            end
            else
            begin
                exp_c = expected_rgb.pop_front();
                if (red !== exp_c.red)
                begin
                    $error("red: expected %0d, actual %0d", exp_c.red, red);
                    errors++;
                end
                if (green !== exp_c.green)
                begin
                    $error("green: expected %0d, actual %0d", exp_c.green, green);
                    errors++;
                end
                if (blue !== exp_c.blue)
                begin
                    $error("blue: expected %0d, actual %0d", exp_c.blue, blue);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_sector_edges();
        test_hue_wrap();
        test_random();
        in_valid <= 1'b0;
        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
